@@ hw/rtl/spq_pkg.sv @@
// Package for the stable priority queue: entry layout, opcodes and status codes.
// No dependencies; imported by stable_priority_queue, spq_order_checker and tb.
`timescale 1ns / 1ps

package spq_pkg;

  localparam int ValueWidth = 16;
  localparam int PrioWidth  = 8;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_POP    = 2'd1;
  localparam opcode_t OP_PEEK   = 2'd2;
  localparam opcode_t OP_CLEAR  = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [PrioWidth-1:0]  prio;
    logic [ValueWidth-1:0] value;
  } entry_t;

endpackage

@@ hw/rtl/stable_priority_queue.sv @@
// Peek, clear, refused insert, insert into an empty queue, empty pop and one-entry pop give
// their beat straight from idle; any other insert first walks back past the entries of higher
// priority number, and a pop of a queue holding more than one entry moves every entry forward.
// The next item is taken at the earliest at the edge at which the result beat leaves, so an
// item holds the block until its result is taken; the walk of the entry memory runs one entry
// per cycle. Reset (rst_n low, synchronous) empties the queue and drops any result not yet
// taken. Depends on spq_pkg.
`timescale 1ns / 1ps

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic [15:0]                         in_entry_value,
  input  logic [7:0]                          in_entry_priority,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [15:0]                         out_front_value,
  output logic [1:0]                          out_status,
  output logic [$clog2(CAPACITY+1)-1:0]       out_entry_count,
  output logic                                out_is_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // The sequencer walks the entry memory one slot per cycle. An insert scans from the
  // back towards the front, moving each entry with a larger priority number one place
  // back, and drops the new entry into the gap; equal priorities stay ahead of it, so
  // arrival order is kept. A pop walks from the front, moving every entry one place
  // forward. The front entry is mirrored in a register so that peeks need no read.
  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_POP
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [IW-1:0]   scan_r;
  entry_t          new_r;
  logic [15:0]     front_r;

  logic            out_valid_r;
  logic [15:0]     out_value_r;
  status_t         out_status_r;
  logic [CW-1:0]   out_count_r;

  // Entry memory: one write and one registered read per cycle.
  entry_t          mem [CAPACITY];
  entry_t          rd_data_r;
  logic [IW-1:0]   rd_addr;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  entry_t          wr_data;

  logic            in_fire;
  logic [IW-1:0]   cnt_m1;
  logic            shift_back;
  entry_t          in_entry;

  // A new item is taken only when the sequencer is idle and the result register is free
  // or being emptied in the same cycle.
  assign in_ready   = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign cnt_m1     = IW'(count_r - CW'(1));
  assign shift_back = rd_data_r.prio > new_r.prio;
  assign in_entry   = '{prio: in_entry_priority, value: in_entry_value};

  assign out_valid       = out_valid_r;
  assign out_front_value = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = (out_count_r == '0);

  // Memory addressing. Reads are issued one step ahead; a read that turns out not to be
  // needed is simply ignored.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = rd_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_opcode == OP_INSERT) begin
          rd_addr = cnt_m1;
        end else begin
          rd_addr = IW'(1);
        end
        if (in_fire && in_opcode == OP_INSERT && count_r == '0) begin
          wr_en   = 1'b1;
          wr_data = in_entry;
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = scan_r + IW'(1);
        rd_addr = scan_r - IW'(1);
        if (!shift_back) begin
          wr_data = new_r;
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_data = new_r;
      end
      S_POP: begin
        wr_en   = 1'b1;
        wr_addr = scan_r - IW'(1);
        rd_addr = scan_r + IW'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer together with the queue state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            new_r        <= in_entry;
            out_status_r <= STATUS_OK;
            out_count_r  <= count_r;
            out_value_r  <= (count_r != '0) ? front_r : 16'd0;
            unique case (in_opcode)
              OP_INSERT: begin
                if (count_r == CW'(CAPACITY)) begin
                  out_status_r <= STATUS_FULL;
                  out_valid_r  <= 1'b1;
                end else if (count_r == '0) begin
                  front_r      <= in_entry_value;
                  count_r      <= CW'(1);
                  out_value_r  <= in_entry_value;
                  out_count_r  <= CW'(1);
                  out_valid_r  <= 1'b1;
                end else begin
                  scan_r  <= cnt_m1;
                  state_r <= S_INS;
                end
              end
              OP_POP: begin
                if (count_r == '0) begin
                  out_status_r <= STATUS_EMPTY;
                  out_valid_r  <= 1'b1;
                end else if (count_r == CW'(1)) begin
                  count_r      <= '0;
                  out_count_r  <= '0;
                  out_valid_r  <= 1'b1;
                end else begin
                  scan_r  <= IW'(1);
                  state_r <= S_POP;
                end
              end
              OP_PEEK: begin
                if (count_r == '0) begin
                  out_status_r <= STATUS_EMPTY;
                end
                out_valid_r <= 1'b1;
              end
              OP_CLEAR: begin
                count_r     <= '0;
                out_value_r <= 16'd0;
                out_count_r <= '0;
                out_valid_r <= 1'b1;
              end
              default: begin
                out_valid_r <= 1'b0;
              end
            endcase
          end
        end
        S_INS: begin
          if (shift_back && scan_r == '0) begin
            state_r <= S_PUT;
          end else if (shift_back) begin
            scan_r <= scan_r - IW'(1);
          end else begin
            // The new entry lands behind the front, so the front stays as it was.
            count_r     <= count_r + CW'(1);
            out_count_r <= count_r + CW'(1);
            out_value_r <= front_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_PUT: begin
          front_r     <= new_r.value;
          count_r     <= count_r + CW'(1);
          out_count_r <= count_r + CW'(1);
          out_value_r <= new_r.value;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_POP: begin
          if (scan_r == IW'(1)) begin
            front_r <= rd_data_r.value;
          end
          if (scan_r == cnt_m1) begin
            count_r     <= count_r - CW'(1);
            out_count_r <= count_r - CW'(1);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            scan_r <= scan_r + IW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/spq_order_checker.sv @@
// Checker for the stable priority queue: keeps its own copy of the entries, predicts every
// result beat and compares it field by field. Depends on spq_pkg; instantiated by tb.
`timescale 1ns / 1ps

module spq_order_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [15:0]                   in_entry_value,
  input  logic [7:0]                    in_entry_priority,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [15:0]                   out_front_value,
  input  logic [1:0]                    out_status,
  input  logic [$clog2(CAPACITY+1)-1:0] out_entry_count,
  input  logic                          out_is_empty,
  output int                            fail_count,
  output int                            outstanding,
  output int                            beats_checked,
  output int                            full_refusals,
  output int                            empty_reports
);

  localparam int CountWidth = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic [ValueWidth-1:0] front_value;
    status_t               status;
    logic [CountWidth-1:0] entry_count;
    logic                  is_empty;
  } queue_result_t;

  // Shadow of the queue, front at index zero.
  entry_t        shadow_entries [CAPACITY];
  int            shadow_held;
  queue_result_t awaited_results [$];
  int            fails;
  int            checked;
  int            refusals;
  int            empties;

  function automatic queue_result_t next_queue_result(opcode_t op, logic [15:0] value,
                                                      logic [7:0] prio);
    queue_result_t res;
    int            slot;
    res = '0;
    res.status = STATUS_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_held >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          // The new entry goes behind everything of equal or smaller priority number.
          slot = 0;
          while (slot < shadow_held && shadow_entries[slot].prio <= prio) slot++;
          for (int i = shadow_held; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[slot].value = value;
          shadow_entries[slot].prio  = prio;
          shadow_held++;
        end
        if (shadow_held > 0) res.front_value = shadow_entries[0].value;
      end
      OP_POP: begin
        if (shadow_held == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.front_value = shadow_entries[0].value;
          for (int i = 1; i < shadow_held; i++) shadow_entries[i-1] = shadow_entries[i];
          shadow_held--;
        end
      end
      OP_PEEK: begin
        if (shadow_held == 0) res.status = STATUS_EMPTY;
        else res.front_value = shadow_entries[0].value;
      end
      OP_CLEAR: begin
        shadow_held = 0;
      end
    endcase
    res.entry_count = CountWidth'(shadow_held);
    res.is_empty    = (shadow_held == 0);
    return res;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch_beats
    queue_result_t want;
    if (rst_n) begin
      // The result side goes first: a beat leaving now cannot belong to an item
      // accepted at this same edge.
      if (out_valid && out_ready) begin
        checked++;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got value %0h status %0d",
                   $time, out_front_value, out_status);
          fails++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("front_value", 32'(want.front_value), 32'(out_front_value));
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
          compare_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
        end
      end
      if (in_valid && in_ready) begin
        want = next_queue_result(in_opcode, in_entry_value, in_entry_priority);
        awaited_results.push_back(want);
        if (want.status == STATUS_FULL) refusals++;
        if (want.status == STATUS_EMPTY) empties++;
      end
    end
    fail_count    <= fails;
    outstanding   <= awaited_results.size();
    beats_checked <= checked;
    full_refusals <= refusals;
    empty_reports <= empties;
  end

  initial begin
    shadow_held = 0;
    fails       = 0;
    checked     = 0;
    refusals    = 0;
    empties     = 0;
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the stable priority queue: clock, reset, stimulus, result sink and verdict.
// Depends on spq_pkg, stable_priority_queue and spq_order_checker.
`timescale 1ns / 1ps

module tb
  import spq_pkg::*;
;

  localparam int CAPACITY      = 16;
  localparam int CountWidth    = $clog2(CAPACITY + 1);
  localparam int Segments      = 14;
  localparam int SegmentItems  = 50;
  localparam int HoldCycles    = 150;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_opcode;
  logic [15:0]           in_entry_value;
  logic [7:0]            in_entry_priority;
  logic                  out_valid;
  logic                  out_ready;
  logic [15:0]           out_front_value;
  logic [1:0]            out_status;
  logic [CountWidth-1:0] out_entry_count;
  logic                  out_is_empty;

  int fail_count;
  int outstanding;
  int beats_checked;
  int full_refusals;
  int empty_reports;

  // Stimulus controls shared between the sender and the result sink.
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  bit rx_hold_req = 1'b0;
  int items_sent  = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  stable_priority_queue #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_entry_value   (in_entry_value),
    .in_entry_priority(in_entry_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_front_value  (out_front_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty)
  );

  spq_order_checker #(
    .CAPACITY(CAPACITY)
  ) order_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_entry_value   (in_entry_value),
    .in_entry_priority(in_entry_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_front_value  (out_front_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .beats_checked    (beats_checked),
    .full_refusals    (full_refusals),
    .empty_reports    (empty_reports)
  );

  // Offers one operation. A random gap with valid low comes first unless the sender is in a
  // steady stretch; the task returns at the edge at which the beat is taken, so a following
  // call with no gap keeps valid high and merely changes the payload.
  task automatic offer_op(opcode_t op, logic [15:0] value, logic [7:0] prio);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_entry_value    <= value;
    in_entry_priority <= prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Pauses the sender until every predicted result has come back. The checker's count is
  // registered, so it is looked at from the edge after the last acceptance onwards.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int          pick;
    int          insert_share;
    opcode_t     op;
    logic [7:0]  prio;
    in_valid          = 1'b0;
    in_opcode         = OP_INSERT;
    in_entry_value    = '0;
    in_entry_priority = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Pop and peek on an empty queue first, with the ignored fields at
    // their top and then their bottom values, then the extremes of value and priority.
    offer_op(OP_POP, 16'hFFFF, 8'hFF);
    offer_op(OP_PEEK, 16'h0000, 8'h00);
    offer_op(OP_INSERT, 16'hFFFF, 8'hFF);
    offer_op(OP_INSERT, 16'h0000, 8'h00);
    // Two entries of equal priority must leave in the order they arrived.
    offer_op(OP_INSERT, 16'h1234, 8'h80);
    offer_op(OP_INSERT, 16'h5678, 8'h80);
    offer_op(OP_POP, 16'h0000, 8'h00);
    offer_op(OP_PEEK, 16'hFFFF, 8'hFF);
    offer_op(OP_CLEAR, 16'hA5A5, 8'h5A);
    // Fill to capacity with a spread of priorities that repeat, then try one more insert,
    // which must be refused with the front left untouched.
    for (int i = 0; i < CAPACITY; i++) begin
      offer_op(OP_INSERT, 16'($urandom), 8'(((i * 5) % 4) * 85));
    end
    offer_op(OP_INSERT, 16'hABCD, 8'h00);
    drain_results();

    // Random part. Segments lean towards inserts, towards a balance, or towards pops, so
    // that the queue swings between full and empty again and again. Some segments run with
    // no idling on either side.
    for (int seg = 0; seg < Segments; seg++) begin
      case (seg % 3)
        0:       insert_share = 70;
        1:       insert_share = 45;
        default: insert_share = 20;
      endcase
      tx_steady = (seg % 4 == 1);
      rx_steady = tx_steady;
      if (seg == 5) begin
        // The result sink holds off for a long stretch while the sender keeps offering
        // beats back to back, so the result register stays full and the block has to stall its input.
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
      end
      for (int k = 0; k < SegmentItems; k++) begin
        pick = $urandom_range(0, 99);
        if (pick >= 97) op = OP_CLEAR;
        else if (pick < insert_share) op = OP_INSERT;
        else if (pick % 3 == 0) op = OP_PEEK;
        else op = OP_POP;
        // Narrow priorities give plenty of ties; the extremes and the full range follow.
        case ($urandom_range(0, 3))
          0:       prio = 8'($urandom_range(0, 3));
          1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = 8'($urandom_range(0, 255));
        endcase
        offer_op(op, 16'($urandom_range(0, 65535)), prio);
      end
      if (seg == 3 || seg == 9) drain_results();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d operations and %0d result beats, among them %0d refused inserts",
             items_sent, beats_checked, full_refusals);
    $display("and %0d pops or peeks on an empty queue.", empty_reports);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result sink: a random stall before each beat, none in steady stretches, and one long
  // hold-off when the sender asks for it.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 12);
      if (rx_hold_req) begin
        stall       = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: any beat on either channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no beat on either channel for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
